// File: src/qfte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfte_pkg
// Shared types, codes and widths for the quadratic form trace estimator.
// ----------------------------------------------------------------------------
package qfte_pkg;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  // configuration register indexes
  localparam logic CFG_SIZE_IN_USE = 1'b0;
  localparam logic CFG_NUM_PROBES  = 1'b1;

  // register widths and reset values
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 7'd32;
  localparam logic [COUNT_W-1:0] PROBES_RESET = 8'd5;

  // datapath widths
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned QW      = 29;   // quad value and estimate
  localparam int unsigned DIV_W   = 30;   // dividend / quotient magnitude
  localparam int unsigned DIV_CW  = 5;    // divider step counter

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_FIN
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/qfte_matrix_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfte_matrix_store
// Matrix entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qfte_matrix_store import qfte_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/qfte_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfte_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qfte_serial_div import qfte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output div_stat_t          stat,
  output logic [DIV_W-1:0]   quotient
);

  logic [DIV_W-1:0]   dvd;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dsr;
  logic [DIV_CW-1:0]  cnt;
  logic               busy;
  logic               done;
  logic [COUNT_W:0]   trial;
  logic               fits;

  // trial subtract of the shifted remainder
  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= COUNT_W'(trial - {1'b0, dsr});
        dvd <= {dvd[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[COUNT_W-1:0];
        dvd <= {dvd[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

// File: src/quadratic_form_trace_estimator_core.sv
`timescale 1ns / 1ps
// A probe does one memory read and accumulate per entry over the n x n entries
// in use (n = dimension in use), plus a 30-step serial divide for every probe
// after the first of a run. One probe is processed at a time; the input stalls
// while it works.
// Reset (rst, synchronous): clears control, estimate and probe count; the
// matrix memory is not cleared and must be written before probing.
// ----------------------------------------------------------------------------
// quadratic_form_trace_estimator_core
// Hutchinson trace estimator: sequencer, shared accumulator and running mean.
// ----------------------------------------------------------------------------
module quadratic_form_trace_estimator_core import qfte_pkg::*; #(
  parameter int unsigned MAX_DIM = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [5:0]            row,
  input  logic [5:0]            col,
  input  logic signed [15:0]    entry,
  input  logic [63:0]           probe_signs,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [28:0]    quad_value,
  output logic signed [28:0]    estimate,
  output logic [7:0]            probe_number,
  output logic                  run_done,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int unsigned IDXW = $clog2(MAX_DIM);
  localparam int unsigned NW   = $clog2(MAX_DIM + 1);
  localparam int unsigned AW   = 2 * IDXW;

  // configuration registers
  logic [SIZE_W-1:0]  size_in_use;
  logic [COUNT_W-1:0] num_probes;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
      num_probes  <= PROBES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_IN_USE: size_in_use <= cfg_data[SIZE_W-1:0];
        CFG_NUM_PROBES:  num_probes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  state_t               state, state_next;
  logic [IDXW-1:0]      i_idx, j_idx;
  logic                 issuing;
  logic                 rd_valid;
  logic                 rd_neg;
  logic [NW-1:0]        n_use;
  logic [MAX_DIM-1:0]   signs;
  logic signed [QW-1:0] acc;
  logic signed [QW-1:0] est;
  logic [COUNT_W-1:0]   pcount;
  logic                 diff_neg;

  logic                 in_accept;
  logic                 out_free;
  logic                 mem_we;
  logic [AW-1:0]        waddr, raddr;
  logic [ENTRY_W-1:0]   rdata;
  logic                 j_last, i_last;
  logic signed [DIV_W-1:0] diff;
  logic [DIV_W-1:0]     diff_mag;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [DIV_W-1:0]     quo;
  logic [QW-1:0]        quo_signed;
  logic [COUNT_W-1:0]   number;
  logic [COUNT_W-1:0]   np_eff;
  logic                 done_run;
  logic [NW-1:0]        n_req;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // matrix writes; out-of-range positions are dropped
  assign mem_we = in_accept && (command == CMD_WRITE) &&
                  ({1'b0, row} < 7'(MAX_DIM)) && ({1'b0, col} < 7'(MAX_DIM));
  assign waddr  = {row[IDXW-1:0], col[IDXW-1:0]};
  assign raddr  = {i_idx, j_idx};

  qfte_matrix_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // dimension in use, saturated to the built size
  assign n_req = (size_in_use > SIZE_W'(MAX_DIM)) ? NW'(MAX_DIM) : size_in_use[NW-1:0];

  assign j_last = ((NW'(j_idx) + NW'(1)) == n_use);
  assign i_last = ((NW'(i_idx) + NW'(1)) == n_use);

  // difference for the running-mean update
  assign diff     = DIV_W'(acc) - DIV_W'(est);
  assign diff_mag = diff[DIV_W-1] ? DIV_W'(-diff) : DIV_W'(diff);
  assign div_start = (state == ST_ACC) && !issuing && !rd_valid && (pcount != '0);

  qfte_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (COUNT_W'(pcount + 1'b1)),
    .stat     (div_stat),
    .quotient (quo)
  );

  assign quo_signed = diff_neg ? QW'(-quo) : quo[QW-1:0];

  // run bookkeeping
  assign number   = COUNT_W'(pcount + 1'b1);
  assign np_eff   = (num_probes == '0) ? COUNT_W'(1) : num_probes;
  assign done_run = (number >= np_eff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept && command == CMD_PROBE) state_next = ST_ACC;
      ST_ACC: begin
        if (!issuing && !rd_valid) begin
          state_next = (pcount == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: if (div_stat.done) state_next = ST_FIN;
      ST_FIN: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read sequencer over the n x n entries
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_ACC) && issuing;
      if (state == ST_IDLE && in_accept && command == CMD_PROBE) begin
        issuing <= (n_req != '0);
      end else if (state == ST_ACC && issuing && j_last && i_last) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      i_idx <= '0;
      j_idx <= '0;
      if (in_accept && command == CMD_PROBE) begin
        n_use <= n_req;
        signs <= probe_signs[MAX_DIM-1:0];
      end
    end else if (state == ST_ACC && issuing) begin
      rd_neg <= signs[i_idx] ^ signs[j_idx];
      if (j_last) begin
        j_idx <= '0;
        i_idx <= i_idx + 1'b1;
      end else begin
        j_idx <= j_idx + 1'b1;
      end
    end
  end

  // shared accumulator
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (state == ST_ACC && rd_valid) begin
      if (rd_neg) begin
        acc <= acc - QW'(signed'(rdata));
      end else begin
        acc <= acc + QW'(signed'(rdata));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      diff_neg <= diff[DIV_W-1];
    end
  end

  // running estimate and probe count
  always_ff @(posedge clk) begin
    if (rst) begin
      est    <= '0;
      pcount <= '0;
    end else begin
      if (state == ST_ACC && !issuing && !rd_valid && pcount == '0) begin
        est <= acc;
      end else if (state == ST_DIV && div_stat.done) begin
        est <= est + signed'(quo_signed);
      end
      if (state == ST_FIN && out_free) begin
        pcount <= done_run ? '0 : number;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      quad_value   <= acc;
      estimate     <= est;
      probe_number <= number;
      run_done     <= done_run;
    end
  end

endmodule
